@@ src/k3sf_pkg.sv @@
// ----------------------------------------------------------------------------
// k3sf_pkg
// Shared types and constants of the 3x3 spatial filter: stream payloads,
// register indexes, coefficient packing and product widths.
// ----------------------------------------------------------------------------
package k3sf_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int COEF_W     = 12;
    localparam int KROW_W     = 3 * COEF_W;
    localparam int CFG_DATA_W = KROW_W;
    localparam int CFG_IDX_W  = 3;
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int ROW_OUT_W  = 12;
    localparam int COL_OUT_W  = 10;
    localparam int OUT_W      = 24;
    // 9-bit signed pixel times 12-bit signed coefficient
    localparam int PROD_W     = 21;
    // nine products
    localparam int SUM_W      = PROD_W + 4;
    localparam int NUM_TAPS   = 9;

    // Reset values of the configuration registers
    localparam logic [KROW_W-1:0] KROW_IDENTITY = 36'h0_0010_0000;
    localparam logic [WCFG_W-1:0] WIDTH_RESET   = 11'd1024;
    localparam logic [HCFG_W-1:0] HEIGHT_RESET  = 13'd768;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KROW_ABOVE  = 3'd0,
        REG_KROW_MIDDLE = 3'd1,
        REG_KROW_BELOW  = 3'd2,
        REG_WIDTH       = 3'd3,
        REG_HEIGHT      = 3'd4,
        REG_FLIP        = 3'd5
    } cfg_reg_t;

    // Input stream payload
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             flush;
    } pix_in_t;

    // Result stream payload
    typedef struct packed {
        logic signed [OUT_W-1:0] filtered;
        logic [ROW_OUT_W-1:0]    out_row;
        logic [COL_OUT_W-1:0]    out_col;
        logic                    last_of_frame;
    } pix_out_t;

    // Border masking and kernel orientation for one result
    typedef struct packed {
        logic skip_above;
        logic skip_below;
        logic skip_left;
        logic skip_right;
        logic flip;
    } tap_ctl_t;

    // Nine tap products, row-major over the window
    typedef logic [NUM_TAPS-1:0][PROD_W-1:0] prod_arr_t;

endpackage

@@ src/k3sf_ram.sv @@
// ----------------------------------------------------------------------------
// k3sf_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module k3sf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Storage array and read register
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/k3sf_window.sv @@
// ----------------------------------------------------------------------------
// k3sf_window
// 3x3 pixel window with its tap multipliers. A new column enters on the
// right at each shift; products of masked taps are forced to zero.
// ----------------------------------------------------------------------------
module k3sf_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic [k3sf_pkg::PIX_W-1:0]    col_above,
    input  logic [k3sf_pkg::PIX_W-1:0]    col_middle,
    input  logic [k3sf_pkg::PIX_W-1:0]    col_below,
    input  logic [k3sf_pkg::KROW_W-1:0]   krow_above,
    input  logic [k3sf_pkg::KROW_W-1:0]   krow_middle,
    input  logic [k3sf_pkg::KROW_W-1:0]   krow_below,
    input  k3sf_pkg::tap_ctl_t            ctl,
    output k3sf_pkg::prod_arr_t           prod
);
    import k3sf_pkg::*;

    logic [PIX_W-1:0] win_reg [3][3];

    // Window shift: columns move left, new column on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= col_above;
            win_reg[1][2] <= col_middle;
            win_reg[2][2] <= col_below;
        end
    end

    // Tap products; with flip set the kernel is read rotated by 180 degrees
    always_comb begin
        logic [KROW_W-1:0]        krow;
        logic signed [PROD_W-1:0] px_ext;
        logic signed [PROD_W-1:0] k_ext;
        logic                     skip;
        int                       rr;
        int                       cc;
        krow   = '0;
        px_ext = '0;
        k_ext  = '0;
        skip   = 1'b0;
        rr     = 0;
        cc     = 0;
        prod   = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                rr   = ctl.flip ? 2 - r : r;
                cc   = ctl.flip ? 2 - c : c;
                krow = (rr == 0) ? krow_above : ((rr == 1) ? krow_middle : krow_below);
                k_ext  = PROD_W'($signed(krow[cc*COEF_W +: COEF_W]));
                px_ext = PROD_W'($signed({1'b0, win_reg[r][c]}));
                skip = (r == 0 && ctl.skip_above) || (r == 2 && ctl.skip_below) ||
                       (c == 0 && ctl.skip_left)  || (c == 2 && ctl.skip_right);
                prod[r*3 + c] = skip ? '0 : px_ext * k_ext;
            end
        end
    end

endmodule

@@ src/kernel3x3_spatial_filter.sv @@
// ----------------------------------------------------------------------------
// kernel3x3_spatial_filter
// 3x3 zero-padded spatial filter over an 8-bit grayscale raster stream.
// ----------------------------------------------------------------------------
// Usage:
//  - s_* channel carries pixels in raster order (valid/ready). An item with
//    flush set is dropped unless the last pixel of the frame is already in;
//    after the last pixel, image_width+1 further items drain the frame.
//  - m_* channel carries one result per image pixel: the signed Q16.8
//    weighted sum plus its row/column and a last-of-frame flag.
//  - The result of raster pixel m is completed by input item m+W+1 and shows
//    on m_valid after that item's transfer (RAM read at the transfer, then
//    window shift, tap multiply, adder tree into the output register).
//  - Throughput is one item per cycle unless m_ready stalls the pipeline; the
//    line RAM has one read and one write port; items use at most one of each.
//  - Each stage only stalls when the one behind it holds a result; items that
//    produce no result never block, so input keeps flowing while a result
//    waits on m_ready as long as the pipeline has room.
//  - Reset (aresetn low, synchronous) clears the counters, the window and
//    the pipeline and loads the register defaults. The line RAM is not
//    cleared; entries are always written before any result uses them.
//  - Configuration writes are only legal while the block is idle.
// ----------------------------------------------------------------------------
module kernel3x3_spatial_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [k3sf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [k3sf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // pixel stream in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  k3sf_pkg::pix_in_t                  s_data,
    // result stream out
    output logic                               m_valid,
    input  logic                               m_ready,
    output k3sf_pkg::pix_out_t                 m_data
);
    import k3sf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);

    // Position and border info carried with an item
    typedef struct packed {
        logic [ROW_OUT_W-1:0] out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 last;
        tap_ctl_t             ctl;
    } tag_t;

    // Configuration registers
    logic [KROW_W-1:0] krow_above_reg;
    logic [KROW_W-1:0] krow_middle_reg;
    logic [KROW_W-1:0] krow_below_reg;
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    logic              flip_reg;

    // Frame counters
    logic [CW-1:0] input_col_reg;
    logic [RW-1:0] input_row_reg;
    logic [CW-1:0] drained_reg;

    // Effective sizes and accept-side decode
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    logic          drain;
    logic          accept;
    logic          accept_item;
    logic [CW-1:0] col;
    logic [RW-1:0] rowpos;
    logic          in_range;
    logic [PIX_W-1:0] pix_eff;
    logic [RW-1:0] orow;
    logic [CW-1:0] ocol;
    logic          res_ok;
    tag_t          tag_next;

    // Stage 1: line RAM read
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic             s1_inr_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_res_reg;
    tag_t             s1_tag_reg;
    logic             fwd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [2*PIX_W-1:0] line_pair;
    logic [PIX_W-1:0] px_above;
    logic [PIX_W-1:0] px_middle;
    logic [2*PIX_W-1:0] ram_wdata;
    logic             ram_we;
    logic             fwd_hit;

    // Stage 2: window, stage 3: products, then output register
    logic       s2_valid_reg;
    tag_t       s2_tag_reg;
    logic       s3_valid_reg;
    tag_t       s3_tag_reg;
    prod_arr_t  prod;
    prod_arr_t  s3_prod_reg;
    logic signed [SUM_W-1:0] sum;
    logic       m_valid_reg;
    pix_out_t   m_data_reg;

    // Handshake chain
    logic out_load;
    logic s3_free;
    logic s2_move;
    logic s2_free;
    logic s1_move;
    logic s1_free;

    // Configuration decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            krow_above_reg  <= '0;
            krow_middle_reg <= KROW_IDENTITY;
            krow_below_reg  <= '0;
            width_reg       <= WIDTH_RESET;
            height_reg      <= HEIGHT_RESET;
            flip_reg        <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KROW_ABOVE:  krow_above_reg  <= cfg_wdata;
                REG_KROW_MIDDLE: krow_middle_reg <= cfg_wdata;
                REG_KROW_BELOW:  krow_below_reg  <= cfg_wdata;
                REG_WIDTH:       width_reg       <= cfg_wdata[WCFG_W-1:0];
                REG_HEIGHT:      height_reg      <= cfg_wdata[HCFG_W-1:0];
                REG_FLIP:        flip_reg        <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp frame size to 1..MAX
    always_comb begin
        if (width_reg == '0) begin
            w_eff = CW'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(width_reg);
        end
        if (height_reg == '0) begin
            h_eff = RW'(1);
        end else if (32'(height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = RW'(MAX_HEIGHT);
        end else begin
            h_eff = RW'(height_reg);
        end
    end

    // Handshake chain: a stage is free when empty or moving on
    assign out_load = s3_valid_reg && (!m_valid_reg || m_ready);
    assign s3_free  = !s3_valid_reg || out_load;
    assign s2_move  = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_move;
    assign s1_move  = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    assign s_ready  = s1_free;

    // Input decode: position, padding and result coordinates
    assign drain       = input_row_reg >= h_eff;
    assign accept      = s_valid && s_ready;
    assign accept_item = accept && !(s_data.flush && !drain);
    assign col         = drain ? drained_reg : input_col_reg;
    assign rowpos      = drain ? h_eff : input_row_reg;
    assign in_range    = col < w_eff;
    assign pix_eff     = (drain || !in_range) ? '0 : s_data.pixel;

    always_comb begin
        if (col == '0) begin
            res_ok = rowpos >= RW'(2);
            orow   = rowpos - RW'(2);
            ocol   = w_eff - CW'(1);
        end else begin
            res_ok = rowpos != '0;
            orow   = rowpos - RW'(1);
            ocol   = col - CW'(1);
        end
        if (orow >= h_eff || ocol >= w_eff) begin
            res_ok = 1'b0;
        end
        tag_next.out_row        = ROW_OUT_W'(orow);
        tag_next.out_col        = COL_OUT_W'(ocol);
        tag_next.last           = (orow == h_eff - RW'(1)) && (ocol == w_eff - CW'(1));
        tag_next.ctl.skip_above = orow == '0;
        tag_next.ctl.skip_below = orow >= h_eff - RW'(1);
        tag_next.ctl.skip_left  = ocol == '0;
        tag_next.ctl.skip_right = ocol >= w_eff - CW'(1);
        tag_next.ctl.flip       = flip_reg;
    end

    // Frame counters advance on every item that is not dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_col_reg <= '0;
            input_row_reg <= '0;
            drained_reg   <= '0;
        end else if (accept_item) begin
            if (drain) begin
                if (drained_reg >= w_eff) begin
                    drained_reg   <= '0;
                    input_col_reg <= '0;
                    input_row_reg <= '0;
                end else begin
                    drained_reg <= drained_reg + CW'(1);
                end
            end else if (input_col_reg >= w_eff - CW'(1)) begin
                input_col_reg <= '0;
                input_row_reg <= input_row_reg + RW'(1);
            end else begin
                input_col_reg <= input_col_reg + CW'(1);
            end
        end
    end

    // Line RAM: entry holds {upper line, lower line} for one column
    assign line_pair = fwd_reg ? fwd_data_reg : ram_rdata;
    assign px_above  = s1_inr_reg ? line_pair[2*PIX_W-1:PIX_W] : '0;
    assign px_middle = s1_inr_reg ? line_pair[PIX_W-1:0] : '0;
    assign ram_wdata = {px_middle, s1_pix_reg};
    assign ram_we    = s1_move && s1_inr_reg;
    // same-column write in the cycle of the read (narrow frames)
    assign fwd_hit   = ram_we && in_range && (s1_addr_reg == col[AW-1:0]);

    k3sf_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (accept_item && in_range),
        .raddr (col[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Stage 1 registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept_item) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_item) begin
            s1_pix_reg   <= pix_eff;
            s1_inr_reg   <= in_range;
            s1_addr_reg  <= col[AW-1:0];
            s1_res_reg   <= res_ok;
            s1_tag_reg   <= tag_next;
            fwd_reg      <= fwd_hit;
            fwd_data_reg <= ram_wdata;
        end
    end

    // Stage 2: window shift; only items with a result continue
    k3sf_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .shift_en    (s1_move),
        .col_above   (px_above),
        .col_middle  (px_middle),
        .col_below   (s1_pix_reg),
        .krow_above  (krow_above_reg),
        .krow_middle (krow_middle_reg),
        .krow_below  (krow_below_reg),
        .ctl         (s2_tag_reg.ctl),
        .prod        (prod)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s1_move) begin
            s2_valid_reg <= s1_res_reg;
        end else if (s2_move) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // Stage 3: registered tap products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (s2_move) begin
            s3_valid_reg <= 1'b1;
        end else if (out_load) begin
            s3_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_move) begin
            s3_prod_reg <= prod;
            s3_tag_reg  <= s2_tag_reg;
        end
    end

    // Adder tree: three row sums, then the total
    always_comb begin
        logic signed [SUM_W-1:0] row_sum [3];
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = SUM_W'($signed(s3_prod_reg[r*3]))
                       + SUM_W'($signed(s3_prod_reg[r*3 + 1]))
                       + SUM_W'($signed(s3_prod_reg[r*3 + 2]));
        end
        sum = row_sum[0] + row_sum[1] + row_sum[2];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.filtered      <= OUT_W'(sum);
            m_data_reg.out_row       <= s3_tag_reg.out_row;
            m_data_reg.out_col       <= s3_tag_reg.out_col;
            m_data_reg.last_of_frame <= s3_tag_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
